// ----- hdl/led_blink_pattern_generator_macros.svh -----
// assertion macros for the led blink pattern generator
`ifndef LED_BLINK_PATTERN_GENERATOR_MACROS_SVH
`define LED_BLINK_PATTERN_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define LBPG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbpg assertion failed");
`define LBPG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lbpg assertion failed");
`else
`define LBPG_ASSERT(lbl, clk, rst_n, prop)
`define LBPG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hdl/lbpg_pkg.sv -----
// types and constants of the led blink pattern generator
package lbpg_pkg;

  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_TIME_W = 16;

  localparam logic [COUNT_W-1:0]    BLINK_COUNT_RST = 4'd3;
  localparam logic [CFG_TIME_W-1:0] ON_TIME_RST     = 16'd100;
  localparam logic [CFG_TIME_W-1:0] OFF_TIME_RST    = 16'd150;
  localparam logic [CFG_TIME_W-1:0] PAUSE_TIME_RST  = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BLINK_COUNT = 8'd0,
    REG_ON_TIME     = 8'd1,
    REG_OFF_TIME    = 8'd2,
    REG_PAUSE_TIME  = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COUNT_W-1:0]    blink_count;
    logic [CFG_TIME_W-1:0] on_time;
    logic [CFG_TIME_W-1:0] off_time;
    logic [CFG_TIME_W-1:0] pause_time;
  } cfg_t;

  typedef struct packed {
    logic led;
    logic running;
  } seq_out_t;

endpackage

// ----- hdl/lbpg_if.sv -----
// request channels of the led blink pattern generator

interface lbpg_in_if;
  logic valid;
  logic ready;
  logic bypass;
  logic restart;

  modport source (output valid, input ready, output bypass, output restart);
  modport sink (input valid, output ready, input bypass, input restart);
endinterface

interface lbpg_out_if;
  logic valid;
  logic ready;
  logic led;
  logic running;

  modport source (output valid, input ready, output led, output running);
  modport sink (input valid, output ready, input led, input running);
endinterface

interface lbpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbpg_pkg::CFG_ADDR_W-1:0] index;
  logic [lbpg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, input ready, output index, output data);
  modport sink (input valid, output ready, input index, input data);
endinterface

// ----- hdl/led_blink_pattern_generator.sv -----
// one tick request in, one led result out, the result is held in a result register
// a result is valid the cycle after its tick request is taken
// throughput: one tick request per cycle, ready drops only while a result waits
// the config port is always ready and its writes apply from the next tick
// reset clears the sequencer, empties the result register and loads default timings
`include "led_blink_pattern_generator_macros.svh"

module led_blink_pattern_generator #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbpg_in_if.sink    in_if,
  lbpg_out_if.source out_if,
  lbpg_cfg_if.sink   cfg_if
);
  import lbpg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  seq_out_t res;
  logic     in_acc;
  logic     out_valid_q, out_valid_d;
  logic     led_q, running_q;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.index))
        REG_BLINK_COUNT: cfg_d.blink_count = cfg_if.data[COUNT_W-1:0];
        REG_ON_TIME:     cfg_d.on_time     = cfg_if.data[CFG_TIME_W-1:0];
        REG_OFF_TIME:    cfg_d.off_time    = cfg_if.data[CFG_TIME_W-1:0];
        REG_PAUSE_TIME:  cfg_d.pause_time  = cfg_if.data[CFG_TIME_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_count <= BLINK_COUNT_RST;
      cfg_q.on_time     <= ON_TIME_RST;
      cfg_q.off_time    <= OFF_TIME_RST;
      cfg_q.pause_time  <= PAUSE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  lbpg_seq #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_acc),
    .bypass_i  (in_if.bypass),
    .restart_i (in_if.restart),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // result register
  assign out_valid_d = in_acc || (out_valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      led_q     <= res.led;
      running_q <= res.running;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.led     = led_q;
  assign out_if.running = running_q;

  `LBPG_ASSERT(a_req_gives_result, clk_i, rst_ni, in_acc |=> out_if.valid)
  `LBPG_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_if.ready |-> out_valid_q)
  `LBPG_ASSERT(a_led_needs_running, clk_i, rst_ni, out_if.valid && out_if.led |-> out_if.running)

endmodule

// ----- hdl/lbpg_seq.sv -----
// blink sequencer state and its per-tick update
`include "led_blink_pattern_generator_macros.svh"

module lbpg_seq #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               bypass_i,
  input  logic               restart_i,
  input  lbpg_pkg::cfg_t     cfg_i,
  output lbpg_pkg::seq_out_t res_o
);
  import lbpg_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;

  logic                  active_q, active_d;
  logic                  lit_q, lit_d;
  logic [COUNT_W-1:0]    idx_q, idx_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [CMP_W-1:0]      elapsed_cmp;
  logic                  on_done, off_done, pause_done;

  // saturating tick count
  assign elapsed_inc = (elapsed_q == {TIME_WIDTH{1'b1}}) ? elapsed_q
                                                         : elapsed_q + TIME_WIDTH'(1);
  assign elapsed_cmp = CMP_W'(elapsed_inc);
  assign on_done     = elapsed_cmp >= CMP_W'(cfg_i.on_time);
  assign off_done    = elapsed_cmp >= CMP_W'(cfg_i.off_time);
  assign pause_done  = elapsed_cmp >= CMP_W'(cfg_i.pause_time);

  always_comb begin
    active_d  = active_q;
    lit_d     = lit_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    if (step_i) begin
      if (bypass_i) begin
        active_d = 1'b0;
        lit_d    = 1'b0;
      end else if (!active_q || restart_i) begin
        active_d  = 1'b1;
        lit_d     = 1'b0;
        idx_d     = '0;
        elapsed_d = '0;
      end else begin
        elapsed_d = elapsed_inc;
        if (lit_q) begin
          if (on_done) begin
            lit_d     = 1'b0;
            elapsed_d = '0;
            idx_d     = idx_q + COUNT_W'(1);
          end
        end else if (idx_q >= cfg_i.blink_count) begin
          if (pause_done) begin
            idx_d     = '0;
            elapsed_d = '0;
          end
        end else if (off_done) begin
          lit_d     = 1'b1;
          elapsed_d = '0;
        end
      end
    end
  end

  always_comb begin
    res_o.led     = lit_d;
    res_o.running = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      lit_q     <= 1'b0;
      idx_q     <= '0;
      elapsed_q <= '0;
    end else begin
      active_q  <= active_d;
      lit_q     <= lit_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
    end
  end

  `LBPG_ASSERT(a_lit_needs_active, clk_i, rst_ni, lit_q |-> active_q)
  `LBPG_ASSERT(a_idle_holds, clk_i, rst_ni, !step_i |=> $stable(elapsed_q) && $stable(idx_q))
  `LBPG_ASSERT(a_bypass_stops, clk_i, rst_ni, step_i && bypass_i |=> !active_q && !lit_q)

endmodule
